>>> hdl/kpc_pkg.sv
// Shared types and constants for the key press classifier with code queue.
// Used by kpc_scan and key_press_classifier_fifo; no dependencies.

package kpc_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_LONG_PRESS_TICKS = 3'd0;
  localparam logic [2:0] REG_REPEAT_TICKS     = 3'd1;
  localparam logic [2:0] REG_SHORT_CODE       = 3'd2;
  localparam logic [2:0] REG_FIRST_LONG_CODE  = 3'd3;
  localparam logic [2:0] REG_REPEAT_CODE      = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [15:0] LONG_PRESS_TICKS_RST = 16'd200;
  localparam logic [15:0] REPEAT_TICKS_RST     = 16'd25;
  localparam logic [7:0]  SHORT_CODE_RST       = 8'd1;
  localparam logic [7:0]  FIRST_LONG_CODE_RST  = 8'd2;
  localparam logic [7:0]  REPEAT_CODE_RST      = 8'd3;

  // Reported press state codes.
  localparam logic [1:0] PRESS_IDLE  = 2'd0;
  localparam logic [1:0] PRESS_SHORT = 2'd1;
  localparam logic [1:0] PRESS_LONG  = 2'd2;

  // Item kinds.
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam logic [15:0] HOLD_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SHORT = 3'b010,
    ST_LONG  = 3'b100
  } scan_state_e;

  typedef struct packed {
    logic [15:0] long_press_ticks;
    logic [15:0] repeat_ticks;
    logic [7:0]  short_code;
    logic [7:0]  first_long_code;
    logic [7:0]  repeat_code;
  } cfg_t;

  // Result of one item before the popped code is known.
  typedef struct packed {
    logic       pop_hit;
    logic [4:0] queued_count;
    logic [1:0] press_state;
    logic       dropped;
  } res_t;

  // One finished result as it waits in the output queue.
  typedef struct packed {
    logic [7:0] key_value;
    logic [4:0] queued_count;
    logic [1:0] press_state;
    logic       dropped;
  } out_t;

endpackage

>>> hdl/kpc_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.

module kpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/kpc_scan.sv
// Key scanner state machine, hold counters and code queue pointers.
// Depends on kpc_pkg; drives the ports of one kpc_ram instance.

module kpc_scan #(
  parameter int FIFO_DEPTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          fire_i,
  input  logic                          kind_i,
  input  logic                          level_i,
  input  kpc_pkg::cfg_t                 cfg_i,
  output logic                          ram_we_o,
  output logic [$clog2(FIFO_DEPTH)-1:0] ram_waddr_o,
  output logic [7:0]                    ram_wdata_o,
  output logic                          ram_re_o,
  output logic [$clog2(FIFO_DEPTH)-1:0] ram_raddr_o,
  output kpc_pkg::res_t                 res_o
);

  localparam int AW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);
  localparam int XW = (CW > 5) ? CW : 5;

  kpc_pkg::scan_state_e state_q, state_d;
  logic [15:0]   short_q, short_d;
  logic [15:0]   long_q, long_d;
  logic [AW-1:0] wptr_q, wptr_d;
  logic [AW-1:0] rptr_q, rptr_d;
  logic [CW-1:0] fill_q, fill_d;
  logic [XW-1:0] fill_ext;
  logic          full;
  logic          empty;
  logic          push;
  logic [7:0]    push_code;
  logic          dropped;
  logic          pop_hit;

  assign full  = (fill_q == CW'(FIFO_DEPTH));
  assign empty = (fill_q == '0);

  always_comb begin
    state_d   = state_q;
    short_d   = short_q;
    long_d    = long_q;
    push      = 1'b0;
    push_code = cfg_i.short_code;
    pop_hit   = 1'b0;

    if (kind_i == kpc_pkg::KIND_READ) begin
      pop_hit = !empty;
    end else begin
      // The counter of the current state advances; the other one clears.
      long_d  = (state_q == kpc_pkg::ST_LONG) ?
                ((long_q == kpc_pkg::HOLD_MAX) ? long_q : long_q + 16'd1) : '0;
      short_d = (state_q == kpc_pkg::ST_SHORT) ?
                ((short_q == kpc_pkg::HOLD_MAX) ? short_q : short_q + 16'd1) : '0;
      unique case (state_q)
        kpc_pkg::ST_SHORT: begin
          if (!level_i) begin
            push      = 1'b1;
            push_code = cfg_i.short_code;
            state_d   = kpc_pkg::ST_IDLE;
          end else if (short_d >= cfg_i.long_press_ticks) begin
            short_d   = '0;
            push      = 1'b1;
            push_code = cfg_i.first_long_code;
            state_d   = kpc_pkg::ST_LONG;
          end
        end
        kpc_pkg::ST_LONG: begin
          if (!level_i) begin
            state_d = kpc_pkg::ST_IDLE;
          end else if (long_d >= cfg_i.repeat_ticks) begin
            long_d    = '0;
            push      = 1'b1;
            push_code = cfg_i.repeat_code;
          end
        end
        default: begin
          state_d = level_i ? kpc_pkg::ST_SHORT : kpc_pkg::ST_IDLE;
        end
      endcase
    end
  end

  assign dropped = push && full;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    fill_d = fill_q;
    if (push && !full) begin
      wptr_d = (wptr_q == AW'(FIFO_DEPTH - 1)) ? '0 : wptr_q + AW'(1);
      fill_d = fill_q + CW'(1);
    end
    if (pop_hit) begin
      rptr_d = (rptr_q == AW'(FIFO_DEPTH - 1)) ? '0 : rptr_q + AW'(1);
      fill_d = fill_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kpc_pkg::ST_IDLE;
      short_q <= '0;
      long_q  <= '0;
      wptr_q  <= '0;
      rptr_q  <= '0;
      fill_q  <= '0;
    end else if (fire_i) begin
      state_q <= state_d;
      short_q <= short_d;
      long_q  <= long_d;
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      fill_q  <= fill_d;
    end
  end

  assign ram_we_o    = fire_i && push && !full;
  assign ram_waddr_o = wptr_q;
  assign ram_wdata_o = push_code;
  assign ram_re_o    = fire_i && pop_hit;
  assign ram_raddr_o = rptr_q;

  assign fill_ext = XW'(fill_d);

  always_comb begin
    res_o.pop_hit      = pop_hit;
    res_o.queued_count = fill_ext[4:0];
    res_o.dropped      = dropped;
    case (state_d)
      kpc_pkg::ST_SHORT: res_o.press_state = kpc_pkg::PRESS_SHORT;
      kpc_pkg::ST_LONG:  res_o.press_state = kpc_pkg::PRESS_LONG;
      default:           res_o.press_state = kpc_pkg::PRESS_IDLE;
    endcase
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(FIFO_DEPTH))
    else $error("queue fill count exceeds depth");

  a_drop_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && dropped) |-> (fill_q == CW'(FIFO_DEPTH) && kind_i == kpc_pkg::KIND_TICK))
    else $error("code dropped while queue had room");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && pop_hit) |=> (fill_q == $past(fill_q) - CW'(1)))
    else $error("pop did not lower the fill count");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q == '0) |-> (wptr_q == rptr_q))
    else $error("empty queue with pointers apart");

endmodule

>>> hdl/key_press_classifier_fifo.sv
// Top level of the key press classifier: config registers, result stage, output queue.
// Depends on kpc_pkg, kpc_scan and kpc_ram.
//
//   channel  | direction | handshake                  | payload
//   ---------+-----------+----------------------------+---------------------------------------
//   in       | sink      | in_valid_i / in_ready_o    | kind_i, level_i
//   out      | source    | out_valid_o / out_ready_i  | key_value_o, queued_count_o,
//            |           |                            | press_state_o, dropped_o
//   cfg      | sink      | cfg_we_i (no wait)         | cfg_index_i, cfg_wdata_i
//
// One item is taken per cycle while in_ready_o is high; its result passes through the result stage,
// which waits on the registered read of the code RAM, and then through the output queue
// register behind it before it is offered.
// A two-entry output queue behind the result stage keeps in_ready_o a registered
// function of occupancy, so a stalled output blocks input only once the result stage
// and both queue entries are full.
// Reset is asynchronous and active low; no clearing pass is needed after it.

module key_press_classifier_fifo #(
  parameter int FIFO_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic        level_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  key_value_o,
  output logic [4:0]  queued_count_o,
  output logic [1:0]  press_state_o,
  output logic        dropped_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_wdata_i
);

  localparam int AW = $clog2(FIFO_DEPTH);

  kpc_pkg::cfg_t cfg_q, cfg_d;
  kpc_pkg::res_t res;
  kpc_pkg::res_t s1_res_q;
  logic          s1_valid_q, s1_valid_d;
  logic          s1_move;
  kpc_pkg::out_t s1_out;
  kpc_pkg::out_t ent0_q, ent0_d;
  kpc_pkg::out_t ent1_q, ent1_d;
  logic [1:0]    qcnt_q, qcnt_d;
  logic          accept;
  logic          out_fire;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  // Configuration registers.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        kpc_pkg::REG_LONG_PRESS_TICKS: cfg_d.long_press_ticks = cfg_wdata_i;
        kpc_pkg::REG_REPEAT_TICKS:     cfg_d.repeat_ticks     = cfg_wdata_i;
        kpc_pkg::REG_SHORT_CODE:       cfg_d.short_code       = cfg_wdata_i[7:0];
        kpc_pkg::REG_FIRST_LONG_CODE:  cfg_d.first_long_code  = cfg_wdata_i[7:0];
        kpc_pkg::REG_REPEAT_CODE:      cfg_d.repeat_code      = cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_press_ticks <= kpc_pkg::LONG_PRESS_TICKS_RST;
      cfg_q.repeat_ticks     <= kpc_pkg::REPEAT_TICKS_RST;
      cfg_q.short_code       <= kpc_pkg::SHORT_CODE_RST;
      cfg_q.first_long_code  <= kpc_pkg::FIRST_LONG_CODE_RST;
      cfg_q.repeat_code      <= kpc_pkg::REPEAT_CODE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Input is held off only when the result stage and both queue entries are taken.
  assign in_ready_o = !(s1_valid_q && qcnt_q == 2'd2);
  assign accept     = in_valid_i && in_ready_o;
  assign out_fire   = out_valid_o && out_ready_i;

  kpc_scan #(
    .FIFO_DEPTH(FIFO_DEPTH)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (accept),
    .kind_i      (kind_i),
    .level_i     (level_i),
    .cfg_i       (cfg_q),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .res_o       (res)
  );

  kpc_ram #(
    .WIDTH(8),
    .DEPTH(FIFO_DEPTH)
  ) u_code_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Result stage. The RAM read data stays put while this stage holds, since
  // the RAM is only read on a transfer.
  assign s1_move = s1_valid_q && (qcnt_q != 2'd2);

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_res_q <= res;
    end
  end

  assign s1_out.key_value    = s1_res_q.pop_hit ? ram_rdata : 8'd0;
  assign s1_out.queued_count = s1_res_q.queued_count;
  assign s1_out.press_state  = s1_res_q.press_state;
  assign s1_out.dropped      = s1_res_q.dropped;

  // Two-entry output queue; ent0_q is the head.
  always_comb begin
    ent0_d = ent0_q;
    ent1_d = ent1_q;
    qcnt_d = qcnt_q;
    case ({s1_move, out_fire})
      2'b10: begin
        if (qcnt_q == 2'd0) begin
          ent0_d = s1_out;
        end else begin
          ent1_d = s1_out;
        end
        qcnt_d = qcnt_q + 2'd1;
      end
      2'b01: begin
        ent0_d = ent1_q;
        qcnt_d = qcnt_q - 2'd1;
      end
      2'b11: begin
        ent0_d = (qcnt_q == 2'd1) ? s1_out : ent1_q;
        ent1_d = s1_out;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qcnt_q <= '0;
    end else begin
      qcnt_q <= qcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent0_q <= ent0_d;
    ent1_q <= ent1_d;
  end

  assign out_valid_o    = (qcnt_q != 2'd0);
  assign key_value_o    = ent0_q.key_value;
  assign queued_count_o = ent0_q.queued_count;
  assign press_state_o  = ent0_q.press_state;
  assign dropped_o      = ent0_q.dropped;

  a_qcnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qcnt_q != 2'd3)
    else $error("output queue count out of range");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && s1_valid_q))
    else $error("input held off with room downstream");

  a_s1_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && qcnt_q != 2'd2 && !accept) |=> !s1_valid_q)
    else $error("result stage failed to move into the output queue");

  a_no_lost_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_move) |=> (s1_valid_q && $stable(s1_res_q)))
    else $error("held result changed before it moved");

endmodule
